// ===== hw/rtl/ple_pkg.sv =====
// Package of the positional list engine: sizes, command codes and sequencer states.
package ple_pkg;

  // Default pool size and stored value width
  localparam int unsigned CapacityDef  = 32;
  localparam int unsigned ValueBitsDef = 32;

  // Fixed widths of the channel fields
  localparam int unsigned CmdW   = 3;
  localparam int unsigned ValW   = 32;
  localparam int unsigned PosW   = 8;
  localparam int unsigned CountW = 7;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT   = 3'd0,
    CMD_DELETE   = 3'd1,
    CMD_READ_FWD = 3'd2,
    CMD_READ_REV = 3'd3,
    CMD_SIZE     = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_LINK,
    S_EMIT,
    S_DONE
  } state_e;

endpackage

// ===== hw/rtl/ple_if.sv =====
// Channel interfaces of the positional list engine: command beats in, result beats out.
interface ple_in_if
  import ple_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CmdW-1:0]        command;
  logic signed [ValW-1:0] value;
  logic [PosW-1:0]        position;

  modport source (output valid, command, value, position, input ready);
  modport sink   (input valid, command, value, position, output ready);
endinterface

interface ple_out_if
  import ple_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] item_value;
  logic                   is_last;
  logic                   list_empty;
  logic                   list_full;
  logic [CountW-1:0]      element_count;

  modport source (output valid, item_value, is_last, list_empty, list_full, element_count,
                  input ready);
  modport sink   (input valid, item_value, is_last, list_empty, list_full, element_count,
                  output ready);
endinterface

// ===== hw/rtl/positional_list_engine.sv =====
// Top level of the positional list engine: linked slot pool in memories plus sequencer.
//
// Bounded ordered list kept as a circular doubly linked list in CAPACITY slots. Value,
// next and prev links sit in three one-port-read memories sharing one read address,
// freed slots go on a free stack memory, never-used slots are handed out by a fill
// count, so nothing needs clearing after reset. One command is worked at a time; the
// walk down the links follows one link per registered memory read. Size, unknown
// commands, a full insert and an empty delete or read go straight to the result beat;
// a read emits one beat per element and waits while the output stalls.
// A new command is accepted while the last result beat still waits in the output
// register.
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY   = CapacityDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ple_in_if.sink       in_i,
  ple_out_if.source    out_o
);

  localparam int unsigned SW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned ExtW = (VALUE_BITS > ValW) ? VALUE_BITS : ValW;

  // Sign-extend an input value and keep VALUE_BITS of it
  function automatic logic [VALUE_BITS-1:0] to_store(input logic signed [ValW-1:0] v);
    logic signed [ExtW-1:0] e;
    e = ExtW'(v);
    return e[VALUE_BITS-1:0];
  endfunction

  // Sign-extend a stored value and present its low ValW bits
  function automatic logic [ValW-1:0] to_out(input logic signed [VALUE_BITS-1:0] v);
    logic signed [ExtW-1:0] e;
    e = ExtW'(v);
    return e[ValW-1:0];
  endfunction

  // Slot memories and free stack
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];
  logic [SW-1:0]         nxt_mem [CAPACITY];
  logic [SW-1:0]         prv_mem [CAPACITY];
  logic [SW-1:0]         fs_mem  [CAPACITY];

  logic [VALUE_BITS-1:0] val_rd_q;
  logic [SW-1:0]         nxt_rd_q, prv_rd_q, fs_rd_q;
  logic [SW-1:0]         rd_addr;

  logic                  val_we, nxt_we, prv_we, nxt_we2, prv_we2, fs_we;
  logic [SW-1:0]         val_wa, nxt_wa, prv_wa, nxt_wa2, prv_wa2;
  logic [VALUE_BITS-1:0] val_wd;
  logic [SW-1:0]         nxt_wd, prv_wd, nxt_wd2, prv_wd2;

  state_e                state_q, state_d;
  cmd_e                  cmd_q, cmd_d;
  logic [SW-1:0]         cur_q, cur_d, head_q, head_d, n_q, n_d, pv_q, pv_d, at_q, at_d;
  logic [CW-1:0]         rem_q, rem_d, cnt_q, cnt_d, hwm_q, hwm_d, fcnt_q, fcnt_d;
  logic [CW-1:0]         k_q, k_d;
  logic                  back_q, back_d, ins_head_q, ins_head_d;
  logic [VALUE_BITS-1:0] v_q, v_d;
  logic [ValW-1:0]       res_val_q, res_val_d;
  logic                  res_empty_q, res_empty_d, res_full_q, res_full_d;

  logic                  ovalid_q, ovalid_d, olast_q, olast_d;
  logic                  oempty_q, oempty_d, ofull_q, ofull_d;
  logic [ValW-1:0]       oval_q, oval_d;
  logic [CountW-1:0]     ocnt_q, ocnt_d;

  logic                  accept, out_free, pos_head, pos_tail;
  logic [SW-1:0]         step, n_new;

  assign in_i.ready          = (state_q == S_IDLE);
  assign accept              = in_i.valid && in_i.ready;
  assign out_free            = !ovalid_q || out_o.ready;
  assign pos_head            = (in_i.position <= PosW'(1));
  assign pos_tail            = (in_i.position >= PosW'(cnt_q));
  assign step                = back_q ? prv_rd_q : nxt_rd_q;
  assign n_new               = (fcnt_q != '0) ? fs_rd_q : hwm_q[SW-1:0];

  assign out_o.valid         = ovalid_q;
  assign out_o.item_value    = oval_q;
  assign out_o.is_last       = olast_q;
  assign out_o.list_empty    = oempty_q;
  assign out_o.list_full     = ofull_q;
  assign out_o.element_count = ocnt_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (in_i.command == CMD_INSERT) begin
            state_d = (cnt_q >= CW'(CAPACITY)) ? S_DONE : S_CHK;
          end else if (in_i.command == CMD_DELETE || in_i.command == CMD_READ_FWD ||
                       in_i.command == CMD_READ_REV) begin
            state_d = (cnt_q == '0) ? S_DONE : S_CHK;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_CHK: begin
        if (rem_q == '0) begin
          unique case (cmd_q)
            CMD_INSERT: state_d = (cnt_q == '0) ? S_DONE : S_LINK;
            CMD_DELETE: state_d = S_DONE;
            default:    state_d = S_EMIT;
          endcase
        end
      end
      S_LINK: state_d = S_DONE;
      S_EMIT: begin
        if (out_free && (k_q == cnt_q - CW'(1))) state_d = S_IDLE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath control and register next values
  always_comb begin
    cmd_d       = cmd_q;
    cur_d       = cur_q;
    head_d      = head_q;
    n_d         = n_q;
    pv_d        = pv_q;
    at_d        = at_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    hwm_d       = hwm_q;
    fcnt_d      = fcnt_q;
    k_d         = k_q;
    back_d      = back_q;
    ins_head_d  = ins_head_q;
    v_d         = v_q;
    res_val_d   = res_val_q;
    res_empty_d = res_empty_q;
    res_full_d  = res_full_q;
    ovalid_d    = ovalid_q && !out_o.ready;
    oval_d      = oval_q;
    olast_d     = olast_q;
    oempty_d    = oempty_q;
    ofull_d     = ofull_q;
    ocnt_d      = ocnt_q;
    rd_addr     = cur_q;
    val_we = 1'b0; nxt_we = 1'b0; prv_we = 1'b0; nxt_we2 = 1'b0; prv_we2 = 1'b0;
    fs_we  = 1'b0;
    val_wa = n_q;  nxt_wa = n_q;  prv_wa = n_q;  nxt_wa2 = pv_q; prv_wa2 = at_q;
    val_wd = v_q;  nxt_wd = cur_q; prv_wd = prv_rd_q; nxt_wd2 = n_q; prv_wd2 = n_q;

    unique case (state_q)
      // Latch the command, start the walk at the head
      S_IDLE: begin
        if (accept) begin
          cmd_d       = cmd_e'(in_i.command);
          v_d         = to_store(in_i.value);
          cur_d       = head_q;
          rd_addr     = head_q;
          k_d         = '0;
          res_val_d   = '0;
          res_empty_d = 1'b0;
          res_full_d  = 1'b0;
          back_d      = 1'b0;
          rem_d       = '0;
          ins_head_d  = pos_head;
          priority if (in_i.command == CMD_INSERT) begin
            res_full_d = (cnt_q >= CW'(CAPACITY));
            if (!pos_head && !pos_tail) rem_d = CW'(in_i.position - PosW'(1));
          end else if (in_i.command == CMD_DELETE) begin
            res_empty_d = (cnt_q == '0);
            if (!pos_head && pos_tail) begin
              back_d = 1'b1;
              rem_d  = CW'(1);
            end else if (!pos_head) begin
              rem_d  = CW'(in_i.position - PosW'(1));
            end
          end else if (in_i.command == CMD_READ_FWD) begin
            res_empty_d = (cnt_q == '0);
          end else if (in_i.command == CMD_READ_REV) begin
            res_empty_d = (cnt_q == '0);
            back_d      = 1'b1;
            rem_d       = CW'(1);
          end else begin
            res_empty_d = 1'b0;
          end
        end
      end
      // Advance along the links, then act on the slot reached
      S_CHK: begin
        if (rem_q != '0) begin
          cur_d   = step;
          rd_addr = step;
          rem_d   = rem_q - CW'(1);
        end else begin
          unique case (cmd_q)
            CMD_INSERT: begin
              n_d = n_new;
              if (fcnt_q != '0) fcnt_d = fcnt_q - CW'(1);
              else              hwm_d  = hwm_q + CW'(1);
              val_we = 1'b1; nxt_we = 1'b1; prv_we = 1'b1;
              val_wa = n_new; nxt_wa = n_new; prv_wa = n_new;
              if (cnt_q == '0) begin
                nxt_wd = n_new;
                prv_wd = n_new;
                head_d = n_new;
                cnt_d  = cnt_q + CW'(1);
              end else begin
                nxt_wd = cur_q;
                prv_wd = prv_rd_q;
                pv_d   = prv_rd_q;
                at_d   = cur_q;
                if (ins_head_q) head_d = n_new;
              end
            end
            CMD_DELETE: begin
              res_val_d = to_out(val_rd_q);
              if (cnt_q > CW'(1)) begin
                nxt_we2 = 1'b1; nxt_wa2 = prv_rd_q; nxt_wd2 = nxt_rd_q;
                prv_we2 = 1'b1; prv_wa2 = nxt_rd_q; prv_wd2 = prv_rd_q;
                if (cur_q == head_q) head_d = nxt_rd_q;
              end else begin
                head_d = '0;
              end
              fs_we  = 1'b1;
              fcnt_d = fcnt_q + CW'(1);
              cnt_d  = cnt_q - CW'(1);
            end
            default: ;
          endcase
        end
      end
      // Close the ring around the new slot
      S_LINK: begin
        nxt_we2 = 1'b1;
        prv_we2 = 1'b1;
        cnt_d   = cnt_q + CW'(1);
      end
      // Emit one element per beat, hold while the sink stalls
      S_EMIT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          oval_d   = to_out(val_rd_q);
          olast_d  = (k_q == cnt_q - CW'(1));
          oempty_d = 1'b0;
          ofull_d  = 1'b0;
          ocnt_d   = CountW'(cnt_q);
          cur_d    = step;
          rd_addr  = step;
          k_d      = k_q + CW'(1);
        end
      end
      // Single result beat
      S_DONE: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          oval_d   = res_val_q;
          olast_d  = 1'b1;
          oempty_d = res_empty_q;
          ofull_d  = res_full_q;
          ocnt_d   = CountW'(cnt_q);
        end
      end
      default: ;
    endcase
  end

  // Slot memories: registered read at one shared address; the free stack is read at its top
  always_ff @(posedge clk_i) begin
    val_rd_q <= val_mem[rd_addr];
    nxt_rd_q <= nxt_mem[rd_addr];
    prv_rd_q <= prv_mem[rd_addr];
    fs_rd_q  <= fs_mem[SW'(fcnt_q - CW'(1))];
  end

  always_ff @(posedge clk_i) begin
    if (val_we)  val_mem[val_wa]  <= val_wd;
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we)       nxt_mem[nxt_wa]  <= nxt_wd;
    else if (nxt_we2) nxt_mem[nxt_wa2] <= nxt_wd2;
  end

  always_ff @(posedge clk_i) begin
    if (prv_we)       prv_mem[prv_wa]  <= prv_wd;
    else if (prv_we2) prv_mem[prv_wa2] <= prv_wd2;
  end

  always_ff @(posedge clk_i) begin
    if (fs_we) fs_mem[fcnt_q[SW-1:0]] <= cur_q;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      cnt_q    <= '0;
      hwm_q    <= '0;
      fcnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      cnt_q    <= cnt_d;
      hwm_q    <= hwm_d;
      fcnt_q   <= fcnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    cur_q       <= cur_d;
    n_q         <= n_d;
    pv_q        <= pv_d;
    at_q        <= at_d;
    rem_q       <= rem_d;
    k_q         <= k_d;
    back_q      <= back_d;
    ins_head_q  <= ins_head_d;
    v_q         <= v_d;
    res_val_q   <= res_val_d;
    res_empty_q <= res_empty_d;
    res_full_q  <= res_full_d;
    oval_q      <= oval_d;
    olast_q     <= olast_d;
    oempty_q    <= oempty_d;
    ofull_q     <= ofull_d;
    ocnt_q      <= ocnt_d;
  end

endmodule
